>>> rtl/g722_adpcm_decoder_defines.svh
// Assertion macros shared by the G.722 decoder RTL.
`ifndef G722_ADPCM_DECODER_DEFINES_SVH
`define G722_ADPCM_DECODER_DEFINES_SVH
`ifndef SYNTH
`define G722_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("g722 assertion failed");
`define G722_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("g722 forbidden condition seen");
`else
`define G722_ASSERT(lbl, prop)
`define G722_NEVER(lbl, expr)
`endif
`endif

>>> rtl/g722_pkg.sv
// Types, constants and quantizer tables of the G.722 decoder.
package g722_pkg;

  typedef logic signed [16:0] mul_op_t;
  typedef logic signed [33:0] mul_prod_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_BAND  = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_QMF   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  localparam logic [1:0] CFG_CODE_BITS = 2'd0;
  localparam logic [1:0] CFG_LOW_ONLY  = 2'd1;
  localparam logic [1:0] CFG_TEST      = 2'd2;

  localparam logic [3:0] MODE_56K = 4'd7;
  localparam logic [3:0] MODE_48K = 4'd6;

  localparam logic [14:0] LOG_MAX_LOW  = 15'd18432;
  localparam logic [14:0] LOG_MAX_HIGH = 15'd22528;
  localparam logic [3:0]  BASE_LOW     = 4'd8;
  localparam logic [3:0]  BASE_HIGH    = 4'd10;
  localparam int R_MAX       = 16383;
  localparam int R_MIN       = -16384;
  localparam int POLE2_DECAY = 32512;
  localparam int LEAK        = 32640;
  localparam int POLE2_LIM   = 12288;
  localparam int POLE1_BASE  = 15360;

  localparam logic signed [12:0] LOW_LOG_INC [8] = '{
    -13'sd60, -13'sd30, 13'sd58, 13'sd172, 13'sd334, 13'sd538, 13'sd1198, 13'sd3042};
  localparam logic [2:0] LOW_LOG_SEL [16] = '{
    3'd0, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1,
    3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
  localparam logic [11:0] STEP_MANT [32] = '{
    12'd2048, 12'd2093, 12'd2139, 12'd2186, 12'd2233, 12'd2282, 12'd2332, 12'd2383,
    12'd2435, 12'd2489, 12'd2543, 12'd2599, 12'd2656, 12'd2714, 12'd2774, 12'd2834,
    12'd2896, 12'd2960, 12'd3025, 12'd3091, 12'd3158, 12'd3228, 12'd3298, 12'd3371,
    12'd3444, 12'd3520, 12'd3597, 12'd3676, 12'd3756, 12'd3838, 12'd3922, 12'd4008};
  localparam logic signed [12:0] HIGH_LOG_INC [3] = '{13'sd0, -13'sd214, 13'sd798};
  localparam logic [1:0] HIGH_LOG_SEL [4] = '{2'd2, 2'd1, 2'd2, 2'd1};
  localparam logic signed [15:0] INV_Q2 [4] = '{-16'sd7408, -16'sd1616, 16'sd7408, 16'sd1616};
  localparam logic signed [15:0] INV_Q4 [16] = '{
    16'sd0, -16'sd20456, -16'sd12896, -16'sd8968, -16'sd6288, -16'sd4240, -16'sd2584,
    -16'sd1200, 16'sd20456, 16'sd12896, 16'sd8968, 16'sd6288, 16'sd4240, 16'sd2584,
    16'sd1200, 16'sd0};
  localparam logic signed [15:0] INV_Q5 [32] = '{
    -16'sd280, -16'sd280, -16'sd23352, -16'sd17560, -16'sd14120, -16'sd11664,
    -16'sd9752, -16'sd8184, -16'sd6864, -16'sd5712, -16'sd4696, -16'sd3784,
    -16'sd2960, -16'sd2208, -16'sd1520, -16'sd880,
    16'sd23352, 16'sd17560, 16'sd14120, 16'sd11664, 16'sd9752, 16'sd8184,
    16'sd6864, 16'sd5712, 16'sd4696, 16'sd3784, 16'sd2960, 16'sd2208,
    16'sd1520, 16'sd880, 16'sd280, -16'sd280};
  localparam logic signed [15:0] INV_Q6 [64] = '{
    -16'sd136, -16'sd136, -16'sd136, -16'sd136, -16'sd24808, -16'sd21904,
    -16'sd19008, -16'sd16704, -16'sd14984, -16'sd13512, -16'sd12280, -16'sd11192,
    -16'sd10232, -16'sd9360, -16'sd8576, -16'sd7856, -16'sd7192, -16'sd6576,
    -16'sd6000, -16'sd5456, -16'sd4944, -16'sd4464, -16'sd4008, -16'sd3576,
    -16'sd3168, -16'sd2776, -16'sd2400, -16'sd2032, -16'sd1688, -16'sd1360,
    -16'sd1040, -16'sd728,
    16'sd24808, 16'sd21904, 16'sd19008, 16'sd16704, 16'sd14984, 16'sd13512,
    16'sd12280, 16'sd11192, 16'sd10232, 16'sd9360, 16'sd8576, 16'sd7856,
    16'sd7192, 16'sd6576, 16'sd6000, 16'sd5456, 16'sd4944, 16'sd4464,
    16'sd4008, 16'sd3576, 16'sd3168, 16'sd2776, 16'sd2400, 16'sd2032,
    16'sd1688, 16'sd1360, 16'sd1040, 16'sd728, 16'sd432, 16'sd136,
    -16'sd432, -16'sd136};
  localparam logic signed [12:0] QMF_TAPS [12] = '{
    13'sd3, -13'sd11, 13'sd12, 13'sd32, -13'sd210, 13'sd951, 13'sd3876, -13'sd805,
    13'sd362, -13'sd156, 13'sd53, -13'sd11};

endpackage

>>> rtl/g722_adpcm_decoder.sv
// Top level of the G.722 sub-band ADPCM decoder with its sequencer.
//
//  channel  | direction | tdata / data             | side bits
//  ---------+-----------+--------------------------+---------------------------
//  s_axis   | in        | [7:0] code               | tlast: end_of_frame
//  m_axis   | out       | [15:0] sample            | tlast: last_of_run,
//           |           |                          | tuser[0]: frame_end
//  cfg      | in        | cfg_data, cfg_index      | cfg_valid / cfg_ready
//
// Each code runs one pass per sub-band (18 multiplies through the shared
// multiplier), one step to shift the QMF delay line and a pass over the 24
// QMF taps, then hands out its words when the output is ready. The input
// reopens once the last word is taken, so a new code is not accepted before
// the last one is through. In low-band-only mode the high band and the QMF
// are skipped; in test mode the QMF is skipped.
// The single multiplier serializes this work. Reset is synchronous and puts all
// predictor state to zero with step sizes 32 and 8. The input is not ready
// while a code is being worked on; a stalled output simply holds.
module g722_adpcm_decoder
  import g722_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] code
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser,   // [0] frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
`include "g722_adpcm_decoder_defines.svh"

  // Step numbers of one band pass; each step issues one multiply and the
  // next cycle consumes its product.
  localparam logic [4:0] OP_RLOW  = 5'd0;
  localparam logic [4:0] OP_DIFF  = 5'd1;
  localparam logic [4:0] OP_POLE2 = 5'd2;
  localparam logic [4:0] OP_POLE1 = 5'd3;
  localparam logic [4:0] OP_ZUPD  = 5'd4;
  localparam logic [4:0] OP_ZUPDL = 5'd9;
  localparam logic [4:0] OP_SP0   = 5'd10;
  localparam logic [4:0] OP_SP1   = 5'd11;
  localparam logic [4:0] OP_ZSUM  = 5'd12;
  localparam logic [4:0] OP_ZSUML = 5'd17;
  localparam logic [4:0] BAND_END = 5'd18;
  localparam logic [4:0] QMF_END  = 5'd24;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    if (v < -32'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] clamp(input logic signed [31:0] v,
                                               input int lo, input int hi);
    if (v > hi) return 16'(hi);
    if (v < lo) return 16'(lo);
    return v[15:0];
  endfunction

  function automatic logic signed [16:0] dbl(input logic signed [15:0] v);
    logic signed [15:0] s;
    s = sat16({{15{v[15]}}, v, 1'b0});
    return {s[15], s};
  endfunction

  function automatic logic signed [31:0] ext19(input logic signed [18:0] v);
    return {{13{v[18]}}, v};
  endfunction

  function automatic logic signed [31:0] ext16(input logic signed [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  state_t state;
  logic [4:0] cnt;
  logic       band;
  logic       out_idx;
  logic       out_two;

  logic [3:0] code_bits;
  logic       low_band_only;
  logic       test_mode;

  logic [7:0] code_q;
  logic       eof_q;

  logic [14:0]        ls    [2];
  logic [15:0]        step  [2];
  logic signed [15:0] se    [2];
  logic signed [15:0] ze    [2];
  logic signed [15:0] rh    [2][2];
  logic signed [15:0] ph    [2][2];
  logic signed [15:0] pa    [2][2];
  logic signed [15:0] zb    [2][6];
  logic signed [15:0] dh    [2][6];
  logic signed [16:0] qd    [24];

  logic signed [15:0] rlow, rhigh, d_q, sp_q;
  logic signed [31:0] acc, acc2;
  logic               dsign_q;
  logic [15:0]        s0, s1;

  mul_op_t   mul_a, mul_b;
  mul_prod_t prod;
  logic signed [18:0] pr;

  g722_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  assign pr = prod[33:15];

  // Code word split for the selected rate.
  logic signed [15:0] q_low;
  logic [3:0]         sel;
  logic [1:0]         hidx;

  always_comb begin
    priority if (code_bits == MODE_56K) begin
      q_low = INV_Q5[code_q[4:0]];
      sel   = code_q[4:1];
      hidx  = code_q[6:5];
    end else if (code_bits == MODE_48K) begin
      q_low = INV_Q4[code_q[3:0]];
      sel   = code_q[3:0];
      hidx  = code_q[5:4];
    end else begin
      q_low = INV_Q6[code_q[5:0]];
      sel   = code_q[5:2];
      hidx  = code_q[7:6];
    end
  end

  // Predictor table read index for the step being issued.
  logic [2:0]         ri;
  logic signed [15:0] zb_rd, dh_rd;

  always_comb begin
    ri = '0;
    if (cnt >= OP_ZUPD && cnt <= OP_ZUPDL) begin
      ri = 3'(cnt - OP_ZUPD);
    end else if (cnt >= OP_ZSUM && cnt <= OP_ZSUML) begin
      ri = 3'(cnt - OP_ZSUM);
    end
  end

  assign zb_rd = zb[band][ri];
  assign dh_rd = dh[band][ri];

  // QMF tap read index.
  logic [4:0] qi;
  logic [3:0] ti;
  assign qi = (cnt < QMF_END) ? cnt : 5'd0;
  assign ti = cnt[0] ? 4'(4'd11 - cnt[4:1]) : cnt[4:1];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_QMF) begin
      mul_a = qd[qi];
      mul_b = {{4{QMF_TAPS[ti][12]}}, QMF_TAPS[ti]};
    end else if (state == ST_BAND) begin
      priority if (cnt == OP_RLOW) begin
        mul_a = {1'b0, step[band]};
        mul_b = {q_low[15], q_low};
      end else if (cnt == OP_DIFF) begin
        mul_a = {1'b0, step[band]};
        mul_b = band ? {INV_Q2[hidx][15], INV_Q2[hidx]} : {INV_Q4[sel][15], INV_Q4[sel]};
      end else if (cnt == OP_POLE2) begin
        mul_a = {pa[band][1][15], pa[band][1]};
        mul_b = 17'(POLE2_DECAY);
      end else if (cnt == OP_POLE1) begin
        mul_a = {pa[band][0][15], pa[band][0]};
        mul_b = 17'(LEAK);
      end else if (cnt >= OP_ZUPD && cnt <= OP_ZUPDL) begin
        mul_a = {zb_rd[15], zb_rd};
        mul_b = 17'(LEAK);
      end else if (cnt == OP_SP0) begin
        mul_a = {pa[band][0][15], pa[band][0]};
        mul_b = dbl(rh[band][0]);
      end else if (cnt == OP_SP1) begin
        mul_a = {pa[band][1][15], pa[band][1]};
        mul_b = dbl(rh[band][1]);
      end else if (cnt >= OP_ZSUM && cnt <= OP_ZSUML) begin
        mul_a = {zb_rd[15], zb_rd};
        mul_b = dbl(dh_rd);
      end else begin
        mul_a = '0;
        mul_b = '0;
      end
    end
  end

  // Band update helpers that depend on the current difference value.
  logic signed [15:0] r0, p0, w1, w2, ap2, ap1s, lim, ap1, zb_new, rx;
  logic signed [16:0] w2n;
  logic signed [31:0] acc_p2;
  logic               n0, n1, n2;
  logic signed [15:0] d_now;

  always_comb begin
    d_now  = pr[15:0];
    r0     = sat16(ext16(se[band]) + ext16(d_q));
    p0     = sat16(ext16(ze[band]) + ext16(d_q));
    n0     = p0[15];
    n1     = ph[band][0][15];
    n2     = ph[band][1][15];
    w1     = sat16({{14{pa[band][0][15]}}, pa[band][0], 2'b00});
    w2n    = (n0 == n1) ? -{w1[15], w1} : {w1[15], w1};
    w2     = (w2n > 17'sd32767) ? 16'sh7fff : w2n[15:0];
    acc_p2 = ((n0 == n2) ? 32'sd128 : -32'sd128) + ext16(w2 >>> 7) + ext19(pr);
    ap2    = clamp(acc_p2, -POLE2_LIM, POLE2_LIM);
    ap1s   = sat16(((n0 == n1) ? 32'sd192 : -32'sd192) + ext19(pr));
    lim    = 16'(POLE1_BASE - int'(pa[band][1]));
    if (ap1s > lim) begin
      ap1 = lim;
    end else if (ap1s < -lim) begin
      ap1 = -lim;
    end else begin
      ap1 = ap1s;
    end
    if (d_q == 16'sd0) begin
      zb_new = sat16(ext19(pr));
    end else if (dsign_q == d_q[15]) begin
      zb_new = sat16(32'sd128 + ext19(pr));
    end else begin
      zb_new = sat16(-32'sd128 + ext19(pr));
    end
    rx = clamp(ext16(d_now) + ext16(se[1]), R_MIN, R_MAX);
  end

  // Log scale factor and step size adaptation.
  logic [21:0]        ls_scaled;
  logic signed [12:0] log_inc;
  logic signed [16:0] nb_raw;
  logic [14:0]        nb, nb_max;
  logic [11:0]        mant;
  logic [3:0]         base, tsh;
  logic [20:0]        stv;
  logic [15:0]        step_new;

  always_comb begin
    ls_scaled = {ls[band], 7'b0} - {7'b0, ls[band]};
    log_inc   = band ? HIGH_LOG_INC[HIGH_LOG_SEL[hidx]] : LOW_LOG_INC[LOW_LOG_SEL[sel]];
    nb_raw    = $signed({2'b00, ls_scaled[21:7]}) + {{4{log_inc[12]}}, log_inc};
    nb_max    = band ? LOG_MAX_HIGH : LOG_MAX_LOW;
    if (nb_raw < 17'sd0) begin
      nb = '0;
    end else if (nb_raw > $signed({2'b00, nb_max})) begin
      nb = nb_max;
    end else begin
      nb = nb_raw[14:0];
    end
    mant = STEP_MANT[nb[10:6]];
    base = band ? BASE_HIGH : BASE_LOW;
    tsh  = nb[14:11];
    if (tsh > base) begin
      stv = {9'b0, mant} << (tsh - base);
    end else begin
      stv = {9'b0, mant} >> (base - tsh);
    end
    step_new = {stv[13:0], 2'b00};
  end

  logic signed [31:0] qsum_odd;
  logic signed [15:0] ze_new;
  assign qsum_odd = acc2 + 32'(prod);
  assign ze_new   = sat16(acc + ext19(pr));

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = out_idx ? s1 : s0;
  assign m_axis_tlast  = (out_idx == out_two);
  assign m_axis_tuser  = (out_idx == out_two) & eof_q;
  assign cfg_ready     = !rst;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits     <= 4'd8;
      low_band_only <= 1'b0;
      test_mode     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CODE_BITS: code_bits     <= cfg_data;
        CFG_LOW_ONLY:  low_band_only <= cfg_data[0];
        CFG_TEST:      test_mode     <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      code_q <= s_axis_tdata;
      eof_q  <= s_axis_tlast;
    end
    if (state == ST_BAND) begin
      if (cnt >= OP_ZUPD && cnt <= OP_ZUPDL) begin
        dsign_q <= dh_rd[15];
      end
      if (cnt == OP_DIFF + 5'd1) begin
        d_q <= d_now;
      end
      if (cnt == OP_SP1 + 5'd1) begin
        sp_q <= sat16(acc + ext19(pr));
      end
    end
  end

  // Sequencer and band state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      band    <= 1'b0;
      out_idx <= 1'b0;
      out_two <= 1'b0;
      rlow    <= '0;
      rhigh   <= '0;
      acc     <= '0;
      acc2    <= '0;
      for (int b = 0; b < 2; b++) begin
        ls[b] <= '0;
        se[b] <= '0;
        ze[b] <= '0;
        for (int i = 0; i < 2; i++) begin
          rh[b][i] <= '0;
          ph[b][i] <= '0;
          pa[b][i] <= '0;
        end
        for (int i = 0; i < 6; i++) begin
          zb[b][i] <= '0;
          dh[b][i] <= '0;
        end
      end
      step[0] <= 16'd32;
      step[1] <= 16'd8;
      for (int i = 0; i < 24; i++) begin
        qd[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_BAND;
            cnt   <= '0;
            band  <= 1'b0;
            rhigh <= '0;
          end
        end
        ST_BAND: begin
          cnt <= (cnt == BAND_END) ? 5'd0 : cnt + 5'd1;
          if (cnt == OP_RLOW + 5'd1 && !band) begin
            rlow <= clamp(ext16(se[0]) + ext19(pr), R_MIN, R_MAX);
          end
          if (cnt == OP_DIFF + 5'd1) begin
            ls[band]   <= nb;
            step[band] <= step_new;
            if (band) begin
              rhigh <= rx;
            end
          end
          if (cnt == OP_POLE2 + 5'd1) begin
            pa[band][1] <= ap2;
          end
          if (cnt == OP_POLE1 + 5'd1) begin
            pa[band][0] <= ap1;
            rh[band][1] <= rh[band][0];
            rh[band][0] <= r0;
            ph[band][1] <= ph[band][0];
            ph[band][0] <= p0;
          end
          if (cnt >= OP_ZUPD + 5'd1 && cnt <= OP_ZUPDL + 5'd1) begin
            zb[band][3'(cnt - OP_ZUPD - 5'd1)] <= zb_new;
          end
          if (cnt == OP_ZUPDL + 5'd1) begin
            for (int i = 5; i > 0; i--) begin
              dh[band][i] <= dh[band][i-1];
            end
            dh[band][0] <= d_q;
          end
          if (cnt == OP_SP0 + 5'd1) begin
            acc <= ext19(pr);
          end
          if (cnt == OP_SP1 + 5'd1) begin
            acc <= '0;
          end
          if (cnt >= OP_ZSUM + 5'd1 && cnt <= OP_ZSUML) begin
            acc <= acc + ext19(pr);
          end
          if (cnt == BAND_END) begin
            ze[band] <= ze_new;
            se[band] <= sat16(ext16(sp_q) + ext16(ze_new));
            if (!band && !low_band_only) begin
              band <= 1'b1;
            end else if (test_mode) begin
              s0      <= {rlow[14:0], 1'b0};
              s1      <= {rhigh[14:0], 1'b0};
              out_two <= 1'b1;
              out_idx <= 1'b0;
              state   <= ST_OUT;
            end else if (low_band_only) begin
              s0      <= rlow;
              out_two <= 1'b0;
              out_idx <= 1'b0;
              state   <= ST_OUT;
            end else begin
              state <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          for (int i = 0; i < 22; i++) begin
            qd[i] <= qd[i+2];
          end
          qd[22] <= {rlow[15], rlow} + {rhigh[15], rhigh};
          qd[23] <= {rlow[15], rlow} - {rhigh[15], rhigh};
          acc    <= '0;
          acc2   <= '0;
          cnt    <= '0;
          state  <= ST_QMF;
        end
        ST_QMF: begin
          cnt <= cnt + 5'd1;
          if (cnt != 5'd0) begin
            if (cnt[0]) begin
              acc <= acc + 32'(prod);
            end else begin
              acc2 <= qsum_odd;
            end
          end
          if (cnt == QMF_END) begin
            s0      <= qsum_odd[27:12];
            s1      <= acc[27:12];
            out_two <= 1'b1;
            out_idx <= 1'b0;
            state   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            if (out_idx == out_two) begin
              state <= ST_IDLE;
            end else begin
              out_idx <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The input side is closed whenever a word waits on the output.
  `G722_NEVER(a_no_overlap, m_axis_tvalid && s_axis_tready)
  // An accepted code always starts with the low band pass.
  `G722_ASSERT(a_start, (s_axis_tvalid && s_axis_tready) |=> (state == ST_BAND && !band))
  // Scale factors stay inside their clamps.
  `G722_NEVER(a_ls_range, ls[0] > LOG_MAX_LOW || ls[1] > LOG_MAX_HIGH)
  // Step sizes never collapse to zero.
  `G722_NEVER(a_step_zero, step[0] == 16'd0 || step[1] == 16'd0)

endmodule

>>> rtl/g722_mul.sv
// Shared signed multiplier with a registered product.
module g722_mul
  import g722_pkg::*;
(
  input  logic      clk,
  input  mul_op_t   a,
  input  mul_op_t   b,
  output mul_prod_t p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
